/* design/huffman_tree_decoder_assert.svh */
// assertion macros shared by the huffman tree decoder modules
// expects clk and rst_n in the scope of each use
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define HTD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define HTD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define HTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/htd_pkg.sv */
// shared constants, action codes and controller/datapath interface types
// for the huffman tree decoder; no dependencies
package htd_pkg;

    localparam int NODE_COUNT   = 512;
    localparam int MAX_CODE_LEN = 32;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 2;
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int WORD_W = SYM_W + 2 * NODE_W;

    localparam int IN_FIELD_W = CODE_W + LEN_W + SYM_W + BYTE_W;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = SYM_W;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DECODE = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear;
        logic ins_start;
        logic dec_start;
        logic rd_child;
        logic ld_word;
        logic leaf_chk;
        logic wr_parent;
        logic alloc;
        logic wr_sym;
        logic emit;
        logic flush;
        logic emit_err;
        logic end_dec;
        logic set_err;
    } htd_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             len_zero;
        logic             sticky;
        logic             child_missing;
        logic             store_full;
        logic             cnt_zero;
        logic             cnt_one;
        logic             sym_nz;
        logic             pend;
        logic             out_free;
    } htd_stat_t;

endpackage

/* design/huffman_tree_decoder.sv */
// huffman_tree_decoder top level: joins htd_ctrl and htd_datapath, depends on htd_pkg
// decode: one node-store read and one read-data stage per walked bit, and an end state
// releases a held symbol; insert: a look and a fetch or allocate step per code bit, then
// a symbol write; clear and ignored requests end at dispatch; one request at a time, s_tready low while busy
// the newest symbol is held until the walk shows it is the last; a full output stalls the walk
// reset (rst_n, async low) empties the tree: root without children, free pointer 1, error clear
module huffman_tree_decoder
    import htd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // code_bits, code_length, code_symbol, data_byte
    input  logic [ACT_W-1:0]      s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_symbol
    output logic                  m_tuser,   // error
    output logic                  m_tlast
);

    htd_cmd_t  cmd;
    htd_stat_t stat;

    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_act    (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_err   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

/* design/htd_ctrl.sv */
// control state machine of the huffman tree decoder
// depends on htd_pkg and huffman_tree_decoder_assert.svh
`include "huffman_tree_decoder_assert.svh"

module htd_ctrl
    import htd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  htd_stat_t stat,
    output htd_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_I_LOOK,
        S_I_FETCH,
        S_I_NEW,
        S_I_SYM,
        S_D_LOAD,
        S_D_LOOK,
        S_D_FETCH,
        S_D_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (stat.act)
                    ACT_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    ACT_INSERT:
                    begin
                        if (!stat.len_zero)
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = S_I_LOOK;
                        end
                    end
                    ACT_DECODE:
                    begin
                        if (!stat.sticky)
                        begin
                            cmd.dec_start = 1'b1;
                            state_next    = S_D_LOAD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_I_LOOK:
            begin
                if (!stat.child_missing)
                begin
                    cmd.rd_child = 1'b1;
                    state_next   = S_I_FETCH;
                end
                else if (stat.store_full)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_err = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.wr_parent = 1'b1;
                    state_next    = S_I_NEW;
                end
            end
            S_I_FETCH:
            begin
                cmd.ld_word = 1'b1;
                state_next  = stat.cnt_zero ? S_I_SYM : S_I_LOOK;
            end
            S_I_NEW:
            begin
                cmd.alloc  = 1'b1;
                state_next = stat.cnt_one ? S_I_SYM : S_I_LOOK;
            end
            S_I_SYM:
            begin
                cmd.wr_sym = 1'b1;
                state_next = S_IDLE;
            end
            S_D_LOAD:
            begin
                cmd.ld_word = 1'b1;
                state_next  = S_D_LOOK;
            end
            S_D_LOOK:
            begin
                if (stat.child_missing)
                begin
                    if (stat.out_free)
                    begin
                        if (stat.pend)
                        begin
                            cmd.flush = 1'b1;
                        end
                        else
                        begin
                            cmd.emit_err = 1'b1;
                            cmd.set_err  = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.rd_child = 1'b1;
                    state_next   = S_D_FETCH;
                end
            end
            S_D_FETCH:
            begin
                if (!stat.sym_nz || !stat.pend || stat.out_free)
                begin
                    cmd.ld_word  = 1'b1;
                    cmd.leaf_chk = 1'b1;
                    cmd.emit     = stat.sym_nz;
                    if (stat.cnt_zero)
                    begin
                        cmd.end_dec = 1'b1;
                        state_next  = (stat.sym_nz || stat.pend) ? S_D_END : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_D_LOOK;
                    end
                end
            end
            S_D_END:
            begin
                if (!stat.pend)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HTD_ASSERT_IMP(a_emit_room, (cmd.emit && stat.pend) || cmd.flush || cmd.emit_err, stat.out_free, "emit into full output")
    `HTD_ASSERT_IMP(a_capture_idle, cmd.capture, state_reg == S_IDLE, "capture outside idle")
    `HTD_ASSERT_NEXT(a_set_err_idle, cmd.set_err, in_ready, "error did not end the byte")

endmodule

/* design/htd_datapath.sv */
// node store, walk registers and output register of the huffman tree decoder
// depends on htd_pkg and huffman_tree_decoder_assert.svh
`include "huffman_tree_decoder_assert.svh"

module htd_datapath
    import htd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [ACT_W-1:0]      in_act,
    input  htd_cmd_t              cmd,
    output htd_stat_t             stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_err,
    output logic                  out_last
);

    // node word: symbol, left link, right link
    logic [WORD_W-1:0] mem [NODE_COUNT];
    logic [WORD_W-1:0] rdata_reg;

    logic [ACT_W-1:0]  act_reg;
    logic [CODE_W-1:0] bits_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [BYTE_W-1:0] byte_reg;

    logic [NODE_W-1:0] root_left_reg;
    logic [NODE_W-1:0] root_right_reg;
    logic [FREE_W-1:0] next_free_reg;
    logic [NODE_W-1:0] walk_reg;
    logic              sticky_reg;
    logic [NODE_W-1:0] node_reg;
    logic [WORD_W-1:0] word_reg;
    logic [CODE_W-1:0] sh_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // newest decoded symbol, held until it is known whether another result follows
    logic              pend_reg;
    logic [SYM_W-1:0]  pend_sym_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_sym_reg;
    logic                  out_err_reg;
    logic                  out_last_reg;

    logic [NODE_W-1:0] cur_left;
    logic [NODE_W-1:0] cur_right;
    logic              cur_bit;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] nf;
    logic [SYM_W-1:0]  rd_sym;
    logic [LEN_W-1:0]  len_clip;
    logic [CNT_W-1:0]  shamt;

    logic              mem_rd_en;
    logic [NODE_W-1:0] mem_rd_addr;
    logic              mem_wr_en;
    logic [NODE_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;

    assign cur_left  = (node_reg == '0) ? root_left_reg  : word_reg[2*NODE_W-1:NODE_W];
    assign cur_right = (node_reg == '0) ? root_right_reg : word_reg[NODE_W-1:0];
    assign cur_bit   = sh_reg[CODE_W-1];
    assign child     = cur_bit ? cur_right : cur_left;
    assign nf        = next_free_reg[NODE_W-1:0];
    assign rd_sym    = rdata_reg[WORD_W-1:2*NODE_W];
    assign len_clip  = (len_reg > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len_reg;
    assign shamt     = CNT_W'(CODE_W) - CNT_W'(len_clip);

    assign stat.act           = act_reg;
    assign stat.len_zero      = (len_reg == '0);
    assign stat.sticky        = sticky_reg;
    assign stat.child_missing = (child == '0);
    assign stat.store_full    = (next_free_reg == FREE_W'(NODE_COUNT));
    assign stat.cnt_zero      = (cnt_reg == '0);
    assign stat.cnt_one       = (cnt_reg == CNT_W'(1));
    assign stat.sym_nz        = (rd_sym != '0);
    assign stat.pend          = pend_reg;
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign mem_rd_en   = cmd.dec_start || cmd.rd_child;
    assign mem_rd_addr = cmd.dec_start ? walk_reg : child;

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = node_reg;
        mem_wr_data = word_reg;
        if (cmd.wr_parent && (node_reg != '0))
        begin
            mem_wr_en = 1'b1;
            if (cur_bit)
            begin
                mem_wr_data = {word_reg[WORD_W-1:NODE_W], nf};
            end
            else
            begin
                mem_wr_data = {word_reg[WORD_W-1:2*NODE_W], nf, word_reg[NODE_W-1:0]};
            end
        end
        else if (cmd.alloc)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = nf;
            mem_wr_data = '0;
        end
        else if (cmd.wr_sym && (node_reg != '0))
        begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {sym_reg, word_reg[2*NODE_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= mem[mem_rd_addr];
        end
    end

    // request fields and walk payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= in_act;
            bits_reg <= in_data[CODE_W-1:0];
            len_reg  <= in_data[CODE_W+LEN_W-1:CODE_W];
            sym_reg  <= in_data[CODE_W+LEN_W+SYM_W-1:CODE_W+LEN_W];
            byte_reg <= in_data[IN_FIELD_W-1:CODE_W+LEN_W+SYM_W];
        end
        if (cmd.ins_start)
        begin
            sh_reg  <= bits_reg << shamt;
            cnt_reg <= CNT_W'(len_clip);
        end
        else if (cmd.dec_start)
        begin
            sh_reg  <= {byte_reg, (CODE_W - BYTE_W)'(0)};
            cnt_reg <= CNT_W'(BYTE_W);
        end
        else if (cmd.rd_child || cmd.alloc)
        begin
            sh_reg  <= sh_reg << 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.ins_start)
        begin
            node_reg <= '0;
        end
        else if (cmd.dec_start)
        begin
            node_reg <= walk_reg;
        end
        else if (cmd.rd_child)
        begin
            node_reg <= child;
        end
        else if (cmd.alloc)
        begin
            node_reg <= nf;
        end
        else if (cmd.leaf_chk && (rd_sym != '0))
        begin
            node_reg <= '0;
        end
        if (cmd.alloc)
        begin
            word_reg <= '0;
        end
        else if (cmd.ld_word)
        begin
            word_reg <= rdata_reg;
        end
        if (cmd.emit)
        begin
            pend_sym_reg <= rd_sym;
        end
        if (cmd.emit && pend_reg)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_err_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_err_reg  <= 1'b0;
            out_last_reg <= (cnt_reg == '0);
        end
        else if (cmd.emit_err)
        begin
            out_sym_reg  <= '0;
            out_err_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    // tree control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_left_reg  <= '0;
            root_right_reg <= '0;
            next_free_reg  <= FREE_W'(1);
            walk_reg       <= '0;
            sticky_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                root_left_reg  <= '0;
                root_right_reg <= '0;
                next_free_reg  <= FREE_W'(1);
                walk_reg       <= '0;
                sticky_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.wr_parent && (node_reg == '0))
                begin
                    if (cur_bit)
                    begin
                        root_right_reg <= nf;
                    end
                    else
                    begin
                        root_left_reg <= nf;
                    end
                end
                if (cmd.alloc)
                begin
                    next_free_reg <= next_free_reg + FREE_W'(1);
                end
                if (cmd.set_err)
                begin
                    walk_reg   <= '0;
                    sticky_reg <= 1'b1;
                end
                else if (cmd.end_dec)
                begin
                    walk_reg <= (rd_sym != '0) ? '0 : node_reg;
                end
            end
            if (cmd.emit)
            begin
                pend_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_reg <= 1'b0;
            end
            if ((cmd.emit && pend_reg) || cmd.flush || cmd.emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_sym_reg;
    assign out_err   = out_err_reg;
    assign out_last  = out_last_reg;

    `HTD_ASSERT(a_free_range, (next_free_reg != '0) && (next_free_reg <= FREE_W'(NODE_COUNT)), "free pointer out of range")
    `HTD_ASSERT_IMP(a_wr_not_root, mem_wr_en, mem_wr_addr != '0, "root written to node store")
    `HTD_ASSERT(a_walk_alloc, FREE_W'(walk_reg) < next_free_reg, "walk position not allocated")

endmodule

/* sim/tb_huffman_tree_decoder.sv */
// testbench for huffman_tree_decoder: directed and random clear, insert and decode
// requests, checked against a built-in code-tree predictor; depends on htd_pkg
`timescale 1ns / 100ps

module tb_huffman_tree_decoder;
    import htd_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  code_symbol;
        logic [BYTE_W-1:0] data_byte;
    } tree_req_t;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             error;
        logic             last;
    } sym_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // shadow code tree
    logic [SYM_W-1:0]  tree_sym  [NODE_COUNT];
    logic [NODE_W-1:0] tree_link [NODE_COUNT][2];
    int unsigned       tree_free;
    int unsigned       tree_walk;
    bit                tree_err;

    sym_result_t symbols_due[$];
    sym_result_t head;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int          fail_count = 0;
    int          effective_count = 0;
    int          full_hits = 0;
    int unsigned cycle_count = 0;

    logic [CODE_W-1:0] tbl_bits [40];
    int                tbl_len  [40];
    int                tbl_n;

    huffman_tree_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_huffman_tree_decoder: done, errors");
            $finish;
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (symbols_due.size() == 0)
            begin
                $error("unexpected result: out_symbol %0h error %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                head = symbols_due.pop_front();
                if (m_tdata !== head.symbol)
                begin
                    $error("out_symbol: expected %0h, got %0h", head.symbol, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== head.error)
                begin
                    $error("error: expected %0b, got %0b", head.error, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== head.last)
                begin
                    $error("last: expected %0b, got %0b", head.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic void reset_tree();
        tree_sym[0] = '0;
        tree_link[0][0] = '0;
        tree_link[0][1] = '0;
        tree_free = 1;
        tree_walk = 0;
        tree_err = 1'b0;
    endfunction

    task automatic apply_to_tree(input tree_req_t r, output bit took_effect);
        sym_result_t res [8];
        int          n;
        int          i;
        int unsigned node;
        int unsigned child;
        bit          stopped;
        logic        b;
        n = 0;
        stopped = 1'b0;
        took_effect = 1'b1;
        case (r.action)
            ACT_CLEAR:
                reset_tree();
            ACT_INSERT:
            begin
                i = int'(r.code_length);
                if (i == 0)
                    took_effect = 1'b0;
                else
                begin
                    if (i > MAX_CODE_LEN)
                        i = MAX_CODE_LEN;
                    node = 0;
                    while (i > 0 && !stopped)
                    begin
                        b = r.code_bits[i-1];
                        child = 32'(tree_link[node][b]);
                        if (child == 0)
                        begin
                            if (tree_free >= NODE_COUNT)
                            begin
                                res[0] = '{'0, 1'b1, 1'b0};
                                n = 1;
                                stopped = 1'b1;
                                full_hits++;
                            end
                            else
                            begin
                                child = tree_free;
                                tree_free++;
                                tree_sym[child] = '0;
                                tree_link[child][0] = '0;
                                tree_link[child][1] = '0;
                                tree_link[node][b] = NODE_W'(child);
                            end
                        end
                        if (!stopped)
                            node = child;
                        i--;
                    end
                    if (!stopped)
                        tree_sym[node] = r.code_symbol;
                end
            end
            ACT_DECODE:
            begin
                if (tree_err)
                    took_effect = 1'b0;
                else
                begin
                    i = 7;
                    while (i >= 0 && !stopped)
                    begin
                        b = r.data_byte[i];
                        child = 32'(tree_link[tree_walk][b]);
                        if (child == 0)
                        begin
                            res[n] = '{'0, 1'b1, 1'b0};
                            n++;
                            tree_err = 1'b1;
                            tree_walk = 0;
                            stopped = 1'b1;
                        end
                        else if (tree_sym[child] != 0)
                        begin
                            res[n] = '{tree_sym[child], 1'b0, 1'b0};
                            n++;
                            tree_walk = 0;
                        end
                        else
                            tree_walk = child;
                        i--;
                    end
                end
            end
            default:
                took_effect = 1'b0;
        endcase
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            symbols_due.push_back(res[i]);
    endtask

    task automatic send_request(input tree_req_t r);
        bit took_effect;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.action;
        s_tdata  <= {r.data_byte, r.code_symbol, r.code_length, r.code_bits};
        do
            @(posedge clk);
        while (!s_tready);
        apply_to_tree(r, took_effect);
        if (took_effect)
            effective_count++;
    endtask

    function automatic tree_req_t make_req(input logic [ACT_W-1:0] act,
                                           input logic [CODE_W-1:0] bits,
                                           input logic [LEN_W-1:0] len,
                                           input logic [SYM_W-1:0] sym,
                                           input logic [BYTE_W-1:0] data);
        tree_req_t r;
        r.action = act;
        r.code_bits = bits;
        r.code_length = len;
        r.code_symbol = sym;
        r.data_byte = data;
        return r;
    endfunction

    task automatic send_clear();
        send_request(make_req(ACT_CLEAR, $urandom, LEN_W'($urandom), SYM_W'($urandom),
                              BYTE_W'($urandom)));
    endtask

    task automatic send_insert(input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len,
                               input logic [SYM_W-1:0] sym);
        send_request(make_req(ACT_INSERT, bits, len, sym, BYTE_W'($urandom)));
    endtask

    task automatic send_decode(input logic [BYTE_W-1:0] data);
        send_request(make_req(ACT_DECODE, $urandom, LEN_W'($urandom), SYM_W'($urandom), data));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (symbols_due.size() != 0)
            @(posedge clk);
    endtask

    // random complete prefix code by splitting leaves; chain mode deepens one branch
    task automatic build_code_table(input int leaves, input int max_len, input bit chain);
        int j;
        int tries;
        tbl_bits[0] = 0;
        tbl_len[0] = 1;
        tbl_bits[1] = 1;
        tbl_len[1] = 1;
        tbl_n = 2;
        tries = 0;
        while (tbl_n < leaves && tries < 200)
        begin
            j = chain ? tbl_n - 1 : $urandom_range(tbl_n - 1);
            tries++;
            if (tbl_len[j] < max_len)
            begin
                tbl_bits[tbl_n] = (tbl_bits[j] << 1) | 1;
                tbl_len[tbl_n] = tbl_len[j] + 1;
                tbl_bits[j] = tbl_bits[j] << 1;
                tbl_len[j]++;
                tbl_n++;
            end
        end
    endtask

    task automatic run_code_groups(input int target);
        int start;
        int j;
        int idx;
        int first;
        int skip;
        int bytes;
        start = effective_count;
        while (effective_count - start < target)
        begin
            if ($urandom_range(9) == 0)
                build_code_table(33, MAX_CODE_LEN, 1'b1);
            else
                build_code_table($urandom_range(2, 24), $urandom_range(2, 12), 1'b0);
            send_clear();
            first = $urandom_range(tbl_n - 1);
            skip = ($urandom_range(99) < 15) ? $urandom_range(tbl_n - 1) : -1;
            for (j = 0; j < tbl_n; j++)
            begin
                idx = (first + j) % tbl_n;
                if (idx != skip)
                    send_insert(tbl_bits[idx], LEN_W'(tbl_len[idx]),
                                SYM_W'(($urandom_range(99) < 5) ? 0 : $urandom_range(1, 255)));
            end
            bytes = $urandom_range(4, 16);
            for (j = 0; j < bytes; j++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    if ($urandom_range(1))
                        send_request(make_req(ACT_UNUSED, $urandom, LEN_W'($urandom),
                                              SYM_W'($urandom), BYTE_W'($urandom)));
                    else
                        send_insert($urandom, LEN_W'($urandom_range(0, 63)), SYM_W'($urandom));
                end
                else
                    send_decode(BYTE_W'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        send_clear();
        send_insert(32'h1234_5678, 6'd0, 8'h11);
        send_request(make_req(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'hFF, 8'hFF));
        send_insert(32'h0, 6'd1, 8'h61);
        send_insert(32'h2, 6'd2, 8'h62);
        send_insert(32'h6, 6'd3, 8'h63);
        send_insert(32'h7, 6'd3, 8'h64);
        send_decode(8'h00);
        // trailing bits leave the walk inside the tree for the next byte
        send_decode(8'hFF);
        send_decode(8'hB6);
        send_insert(32'h2, 6'd2, 8'hFF);
        send_decode(8'h80);
        send_insert(32'hFFFF_FFFF, 6'd32, 8'h01);
        // over-long code is cut to the maximum length
        send_insert(32'h8000_0000, 6'd63, 8'h7E);
        send_decode(8'h4C);
        send_clear();
        send_insert(32'h1, 6'd1, 8'h55);
        // symbol then missing child, then sticky error drops the next byte
        send_decode(8'h80);
        send_decode(8'hFF);
        send_insert(32'h0, 6'd1, 8'hAA);
        send_clear();
        // zero symbol does not end a code
        send_insert(32'h0, 6'd1, 8'h00);
        send_insert(32'h1, 6'd2, 8'h07);
        send_decode(8'h40);
        drain_results();
    endtask

    task automatic test_store_full();
        int tries;
        int j;
        int hits_at_start;
        hits_at_start = full_hits;
        tries = 0;
        send_clear();
        while (full_hits == hits_at_start && tries < 60)
        begin
            send_insert($urandom, 6'd32, SYM_W'($urandom_range(1, 255)));
            tries++;
        end
        for (j = 0; j < 6; j++)
            send_decode(BYTE_W'($urandom));
        drain_results();
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_code_groups(100);
        drain_results();
        send_idle_pct = 49;
        run_code_groups(100);
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 49;
        run_code_groups(100);
        drain_results();
        send_idle_pct = 19;
        recv_stall_pct = 19;
        run_code_groups(100);
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        int j;
        send_clear();
        send_insert(32'h0, 6'd1, SYM_W'($urandom_range(1, 255)));
        send_insert(32'h1, 6'd1, SYM_W'($urandom_range(1, 255)));
        drain_results();
        @(posedge clk);
        hold_left = 300;
        // every byte yields eight symbols, so the block backs up quickly
        for (j = 0; j < 24; j++)
            send_decode(BYTE_W'($urandom));
        drain_results();
    endtask

    initial
    begin
        reset_tree();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_store_full();
        test_random_traffic();
        test_output_backpressure();
        drain_results();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && symbols_due.size() == 0)
            $display("tb_huffman_tree_decoder: done, clean");
        else
            $display("tb_huffman_tree_decoder: done, errors");
        $finish;
    end

endmodule
